// ----- src/flash_eeprom_emulation_store_macros.svh -----
// assertion macros for the flash eeprom emulation store
// used by the top level, which supplies clk_i and rst_ni

`ifndef FLASH_EEPROM_EMULATION_STORE_MACROS_SVH
`define FLASH_EEPROM_EMULATION_STORE_MACROS_SVH

// checked only while out of reset
`define FEES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FEES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/fees_pkg.sv -----
// constants, types and helpers for the flash eeprom emulation store
// no dependencies

package fees_pkg;

  localparam int NUM_VARS   = 64;
  localparam int PAGE_BYTES = 1024;   // power of two

  localparam int NAME_W    = 14;
  localparam int VAL_W     = 64;
  localparam int HW_W      = 16;
  localparam int IDX_W     = $clog2(NUM_VARS);
  localparam int PG_BIT    = $clog2(PAGE_BYTES);
  localparam int OFF_W     = $clog2(2 * PAGE_BYTES) + 1;
  localparam int FL_DEPTH  = PAGE_BYTES;  // two pages of halfwords
  localparam int FL_AW     = $clog2(FL_DEPTH);
  localparam int LIVE_W    = $clog2(PAGE_BYTES + 1);

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_NAME   = 2'd1;
  localparam logic [1:0] ST_UNASSIGNED = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  typedef struct packed {
    logic [1:0]       size;
    logic [OFF_W-1:0] off;
  } fees_tab_t;

  // value bytes for a size code
  function automatic logic [3:0] data_bytes(input logic [1:0] code);
    logic [3:0] r;
    case (code)
      2'd1:    r = 4'd2;
      2'd2:    r = 4'd4;
      2'd3:    r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // bytes a live record takes, header included
  function automatic logic [4:0] rec_bytes(input logic [1:0] code);
    return (code == 2'd0) ? 5'd0 : 5'd2 + {1'b0, data_bytes(code)};
  endfunction

endpackage

// ----- src/fees_if.sv -----
// item channels of the flash eeprom emulation store
// depends on fees_pkg

interface fees_in_if import fees_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [NAME_W-1:0] var_name;
  logic [VAL_W-1:0]  write_value;
  logic [1:0]        size_code;

  modport source (output valid, cmd, var_name, write_value, size_code, input ready);
  modport sink   (input valid, cmd, var_name, write_value, size_code, output ready);
endinterface

interface fees_out_if import fees_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [VAL_W-1:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink   (input valid, status, read_value, output ready);
endinterface

// ----- src/flash_eeprom_emulation_store.sv -----
// flash eeprom emulation store: named variables kept as records in a two-page flash
// depends on fees_pkg, fees_if.sv and flash_eeprom_emulation_store_macros.svh
//
//  channel  dir  handshake     payload
//  in_i     in   valid/ready   cmd, var_name, write_value, size_code
//  out_o    out  valid/ready   status, read_value
//
// one item at a time through a small sequencer; ready again the cycle after the result step
// read: decide, a read per halfword plus one, result; a failure goes straight to result
// write/delete: decide, a write per halfword, header, result; a failure skips the writes
// page transfer: check each table entry, copy each live record still on the old page
// after reset the block is ready at once; no clearing pass, flash is read only where written
// a finished result waits in the output register; a full register stalls only the result step

module flash_eeprom_emulation_store import fees_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fees_in_if.sink   in_i,
  fees_out_if.source out_o
);

  // sequencer codes
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DEC      = 3'd1;
  localparam logic [2:0] S_FETCH    = 3'd2;
  localparam logic [2:0] S_WRITE    = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_SCAN_CHK = 3'd5;
  localparam logic [2:0] S_RES      = 3'd6;

  localparam int PG_HI_W = OFF_W - PG_BIT;

  // control state
  logic [2:0]                state_q, state_d;
  logic                      out_vld_q, out_vld_d;
  logic                      valid_q, valid_d;      // valid page
  logic                      wpage_q, wpage_d;      // page being appended to
  logic                      xfer_q, xfer_d;        // page transfer in progress
  logic [OFF_W-1:0]          nf_q, nf_d;            // next free byte offset, zero when full
  logic [LIVE_W-1:0]         live_q, live_d;        // bytes of all live records
  logic [NUM_VARS-1:0]       tab_vld_q;

  // item payload and work registers
  logic [1:0]        cmd_q, cmd_d;
  logic [NAME_W-1:0] name_q, name_d;
  logic [1:0]        code_q, code_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [OFF_W-1:0]  src_q, src_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              copy_q, copy_d;
  logic [1:0]        status_q, status_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [VAL_W-1:0]  out_rv_q, out_rv_d;

  // flash memory
  logic [HW_W-1:0]  flash_mem [FL_DEPTH];
  logic             fl_we;
  logic [FL_AW-1:0] fl_waddr, fl_raddr;
  logic [HW_W-1:0]  fl_wdata, fl_rdata_q;

  // variable table: size code and offset per name, valid bits give the reset value
  fees_tab_t        tab_mem [NUM_VARS];
  logic             tab_we;
  logic [IDX_W-1:0] tab_waddr, tab_raddr;
  fees_tab_t        tab_wdata, tab_rdata_q;
  logic             tab_hit_q;

  always_ff @(posedge clk_i) begin
    if (fl_we) begin
      flash_mem[fl_waddr] <= fl_wdata;
    end
    fl_rdata_q <= flash_mem[fl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rdata_q <= tab_mem[tab_raddr];
    tab_hit_q   <= tab_vld_q[tab_raddr];
  end

  // table entry just read; an entry never written reads as deleted
  logic [1:0]       tab_size;
  logic [OFF_W-1:0] tab_off;
  assign tab_size = tab_hit_q ? tab_rdata_q.size : 2'd0;
  assign tab_off  = tab_rdata_q.off;

  // value halfword count of the record being read, written or moved
  logic [3:0] db;
  logic [2:0] nh;
  logic [2:0] cm1;
  assign db  = data_bytes(code_q);
  assign nh  = db[3:1];
  assign cm1 = cnt_q - 3'd1;

  // page bounds
  logic [OFF_W-1:0] vend, wend, obase, rec_end, need, req;
  logic [OFF_W-1:0] live_new;
  assign vend    = (OFF_W'(valid_q) << PG_BIT) + OFF_W'(PAGE_BYTES);
  assign wend    = (OFF_W'(wpage_q) << PG_BIT) + OFF_W'(PAGE_BYTES);
  assign obase   = OFF_W'(!valid_q) << PG_BIT;
  assign rec_end = nf_q + OFF_W'(2) + OFF_W'(db);
  assign need    = OFF_W'(2) + OFF_W'(db);
  // space for the reserved halfword, the new record and every other live record
  assign req     = OFF_W'(2) + need + OFF_W'(live_q) - OFF_W'(rec_bytes(tab_size));
  assign live_new = OFF_W'(live_q) - OFF_W'(rec_bytes(tab_size)) + OFF_W'(rec_bytes(code_q));

  logic fits, on_old, last_idx;
  assign fits     = (nf_q != '0) && ((vend - nf_q) >= need);
  assign on_old   = (tab_off[OFF_W-1:PG_BIT] == PG_HI_W'(valid_q)) && (tab_off[PG_BIT-1:0] != '0);
  assign last_idx = (idx_q == IDX_W'(NUM_VARS - 1));

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.status     = out_status_q;
  assign out_o.read_value = out_rv_q;

  always_comb begin
    state_d      = state_q;
    out_vld_d    = out_vld_q;
    valid_d      = valid_q;
    wpage_d      = wpage_q;
    xfer_d       = xfer_q;
    nf_d         = nf_q;
    live_d       = live_q;
    cmd_d        = cmd_q;
    name_d       = name_q;
    code_d       = code_q;
    val_d        = val_q;
    idx_d        = idx_q;
    src_d        = src_q;
    cnt_d        = cnt_q;
    copy_d       = copy_q;
    status_d     = status_q;
    out_status_d = out_status_q;
    out_rv_d     = out_rv_q;
    fl_we        = 1'b0;
    fl_waddr     = nf_q[FL_AW:1];
    fl_wdata     = val_q[HW_W-1:0];
    fl_raddr     = src_q[FL_AW:1];
    tab_we       = 1'b0;
    tab_waddr    = idx_q;
    tab_wdata    = '{size: code_q, off: (code_q != 2'd0) ? nf_q + OFF_W'(2) : '0};
    tab_raddr    = idx_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        tab_raddr = in_i.var_name[IDX_W-1:0];
        if (in_i.valid) begin
          cmd_d   = in_i.cmd;
          name_d  = in_i.var_name;
          val_d   = in_i.write_value;
          code_d  = (in_i.cmd == CMD_DELETE) ? 2'd0 : in_i.size_code;
          idx_d   = in_i.var_name[IDX_W-1:0];
          copy_d  = 1'b0;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        status_d = ST_OK;
        cnt_d    = '0;
        if (cmd_q != CMD_READ && cmd_q != CMD_WRITE && cmd_q != CMD_DELETE) begin
          state_d = S_RES;
        end else if (name_q >= NAME_W'(NUM_VARS)) begin
          status_d = ST_BAD_NAME;
          state_d  = S_RES;
        end else if (cmd_q == CMD_READ) begin
          if (tab_size == 2'd0) begin
            status_d = ST_UNASSIGNED;
            state_d  = S_RES;
          end else begin
            code_d  = tab_size;
            src_d   = tab_off;
            val_d   = '0;
            state_d = S_FETCH;
          end
        end else if (fits) begin
          wpage_d = valid_q;
          live_d  = live_new[LIVE_W-1:0];
          state_d = S_WRITE;
        end else if (req > OFF_W'(PAGE_BYTES)) begin
          status_d = ST_FULL;
          state_d  = S_RES;
        end else begin
          // open the erased page and put the new record first
          xfer_d  = 1'b1;
          wpage_d = !valid_q;
          nf_d    = obase + OFF_W'(2);
          live_d  = live_new[LIVE_W-1:0];
          state_d = S_WRITE;
        end
      end

      // one read issued per cycle, its data captured in the following cycle
      S_FETCH: begin
        fl_raddr = FL_AW'((src_q + OFF_W'({cnt_q, 1'b0})) >> 1);
        if (cnt_q != 3'd0) begin
          val_d[HW_W*cm1[1:0] +: HW_W] = fl_rdata_q;
        end
        if (cnt_q == nh) begin
          cnt_d = '0;
          if (cmd_q == CMD_READ) begin
            state_d = S_RES;
          end else begin
            state_d = S_WRITE;
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end

      // value halfwords first, header last
      S_WRITE: begin
        fl_we = 1'b1;
        if (cnt_q != nh) begin
          fl_waddr = FL_AW'((nf_q + OFF_W'(2) + OFF_W'({cnt_q, 1'b0})) >> 1);
          fl_wdata = val_q[HW_W*cnt_q[1:0] +: HW_W];
          cnt_d    = cnt_q + 3'd1;
        end else begin
          fl_wdata = {code_q, name_q};
          tab_we   = 1'b1;
          nf_d     = (rec_end >= wend) ? '0 : rec_end;
          cnt_d    = '0;
          if (!xfer_q) begin
            state_d = S_RES;
          end else if (!copy_q) begin
            idx_d   = '0;
            state_d = S_SCAN;
          end else if (last_idx) begin
            valid_d = wpage_q;
            xfer_d  = 1'b0;
            state_d = S_RES;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        state_d = S_SCAN_CHK;
      end

      // copy a live record still held on the old page
      S_SCAN_CHK: begin
        if (tab_size != 2'd0 && on_old) begin
          copy_d  = 1'b1;
          name_d  = NAME_W'(idx_q);
          code_d  = tab_size;
          src_d   = tab_off;
          val_d   = '0;
          cnt_d   = '0;
          state_d = S_FETCH;
        end else if (last_idx) begin
          valid_d = wpage_q;
          xfer_d  = 1'b0;
          state_d = S_RES;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_SCAN;
        end
      end

      S_RES: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = status_q;
          out_rv_d     = (cmd_q == CMD_READ && status_q == ST_OK) ? val_q : '0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      valid_q   <= 1'b0;
      wpage_q   <= 1'b0;
      xfer_q    <= 1'b0;
      nf_q      <= OFF_W'(2);
      live_q    <= '0;
      tab_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      valid_q   <= valid_d;
      wpage_q   <= wpage_d;
      xfer_q    <= xfer_d;
      nf_q      <= nf_d;
      live_q    <= live_d;
      if (tab_we) begin
        tab_vld_q[tab_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    name_q       <= name_d;
    code_q       <= code_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    src_q        <= src_d;
    cnt_q        <= cnt_d;
    copy_q       <= copy_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_rv_q     <= out_rv_d;
  end

  `include "flash_eeprom_emulation_store_macros.svh"

  `FEES_ASSERT(a_res_from_seq, $rose(out_vld_q) |-> $past(state_q) == S_RES, "result without result step")
  `FEES_ASSERT(a_rv_only_ok, out_vld_q && out_rv_q != '0 |-> out_status_q == ST_OK, "value with failure status")
  `FEES_ASSERT_ALWAYS(a_live_fits, OFF_W'(live_q) + OFF_W'(2) <= OFF_W'(PAGE_BYTES), "live data exceeds page")
  `FEES_ASSERT(a_nf_on_page, state_q == S_IDLE && nf_q != '0 |-> nf_q[PG_BIT] == valid_q, "free offset off valid page")

endmodule

// ----- tb/tb_flash_eeprom_emulation_store.sv -----
// testbench for the flash eeprom emulation store: directed and random read/write/delete items
// checked against an in-bench model of the two-page flash; depends on fees_pkg and fees_if.sv
`timescale 1ns / 1ps

module tb_flash_eeprom_emulation_store;
  import fees_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NO_PAGE     = 2;
  localparam int RAND_ITEMS  = 310;  // per idling phase, four phases

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
  } result_t;

  logic clk_i;
  logic rst_ni;

  fees_in_if  in_if ();
  fees_out_if out_if ();

  flash_eeprom_emulation_store u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // model of the store: flash halfwords, offset and size tables, page roles
  logic [15:0] flash_mem [FL_DEPTH];
  int          offset_of [NUM_VARS];
  int          size_of   [NUM_VARS];
  int          valid_pg, recv_pg, erased_pg, free_off;

  result_t     pending_results[$];
  int          fail_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int value_bytes(int code);
    return (code == 0) ? 0 : (1 << code);
  endfunction

  function automatic void flash_put(int off, logic [15:0] v);
    if ((off >> 1) < FL_DEPTH) flash_mem[off >> 1] = v;
  endfunction

  function automatic logic [15:0] flash_get(int off);
    return ((off >> 1) < FL_DEPTH) ? flash_mem[off >> 1] : 16'hFFFF;
  endfunction

  // value halfwords are stored least significant first
  function automatic logic [63:0] flash_value(int off, int code);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < value_bytes(code) / 2; k++)
      v |= 64'(flash_get(off + 2 * k)) << (16 * k);
    return v;
  endfunction

  function automatic int target_page();
    return (recv_pg != NO_PAGE) ? recv_pg : valid_pg;
  endfunction

  // one record: header halfword, then the value halfwords
  function automatic void append_record(int name, logic [63:0] v, int code);
    int off, n, lim;
    off = free_off;
    n   = value_bytes(code);
    lim = target_page() * PAGE_BYTES + PAGE_BYTES;
    for (int k = 0; k < n / 2; k++)
      flash_put(off + 2 + 2 * k, v[16*k +: 16]);
    flash_put(off, {code[1:0], name[13:0]});
    if (name < NUM_VARS) begin
      offset_of[name] = (code != 0) ? off + 2 : 0;
      size_of[name]   = code;
    end
    free_off = off + 2 + n;
    if (free_off >= lim) free_off = 0;
  endfunction

  function automatic void erase_pg(int pg);
    int base;
    base = pg * PAGE_BYTES;
    for (int i = 0; i < NUM_VARS; i++)
      if (base < offset_of[i] && offset_of[i] < base + PAGE_BYTES) offset_of[i] = 0;
    for (int i = 0; i < PAGE_BYTES; i += 2) flash_put(base + i, 16'hFFFF);
  endfunction

  // append, or when the active page is full open the other page, put the new record first and move live data after it
  function automatic logic [1:0] store_record(int name, logic [63:0] v, int code);
    int need, lim, req, base, off;
    need = 2 + value_bytes(code);
    lim  = target_page() * PAGE_BYTES + PAGE_BYTES;
    if (free_off != 0 && free_off <= lim && lim - free_off >= need) begin
      append_record(name, v, code);
      return ST_OK;
    end
    // reserved halfword, new record and every other live record must fit
    req = 2 + need;
    for (int i = 0; i < NUM_VARS; i++)
      if (i != name && size_of[i] != 0) req += 2 + value_bytes(size_of[i]);
    if (req > PAGE_BYTES) return ST_FULL;
    recv_pg   = erased_pg;
    erased_pg = NO_PAGE;
    free_off  = recv_pg * PAGE_BYTES + 2;
    append_record(name, v, code);
    base = valid_pg * PAGE_BYTES;
    for (int i = 0; i < NUM_VARS; i++) begin
      off = offset_of[i];
      if (base < off && off < base + PAGE_BYTES && size_of[i] != 0)
        append_record(i, flash_value(off, size_of[i]), size_of[i]);
    end
    erase_pg(valid_pg);
    erased_pg = valid_pg;
    valid_pg  = recv_pg;
    recv_pg   = NO_PAGE;
    return ST_OK;
  endfunction

  function automatic result_t predict_result(logic [1:0] cmd, int name, logic [63:0] wval,
                                             logic [1:0] code);
    result_t r;
    r = '0;
    if (cmd == CMD_READ) begin
      if (name >= NUM_VARS) r.status = ST_BAD_NAME;
      else if (offset_of[name] == 0 || size_of[name] == 0) r.status = ST_UNASSIGNED;
      else r.value = flash_value(offset_of[name], size_of[name]);
    end else if (cmd == CMD_WRITE || cmd == CMD_DELETE) begin
      if (name >= NUM_VARS) r.status = ST_BAD_NAME;
      else if (cmd == CMD_WRITE) r.status = store_record(name, wval, int'(code));
      else r.status = store_record(name, '0, 0);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // one item: optional idle gap, then hold valid until the block takes it
  task automatic send_item(input logic [1:0] cmd, input logic [NAME_W-1:0] name,
                           input logic [63:0] wval, input logic [1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
    @(negedge clk_i);
    in_if.valid       = 1'b1;
    in_if.cmd         = cmd;
    in_if.var_name    = name;
    in_if.write_value = wval;
    in_if.size_code   = code;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_result(cmd, int'(name), wval, code));
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // result checker: oldest expectation first
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item status", 64'(out_if.status), 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", 64'(out_if.status), 64'(want.status));
        if (out_if.read_value !== want.value)
          report_mismatch("read_value", out_if.read_value, want.value);
      end
    end
  end

  // receiver stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // extremes, every command, bad names, size zero, delete of unassigned, unused command
  task automatic test_directed();
    send_item(CMD_READ, 14'd0, '0, 2'd1);
    send_item(CMD_WRITE, 14'd0, 64'hFFFF_FFFF_FFFF_FFFF, 2'd1);
    send_item(CMD_WRITE, 14'd1, 64'hFFFF_FFFF_FFFF_FFFF, 2'd2);
    send_item(CMD_WRITE, 14'd63, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3);
    send_item(CMD_READ, 14'd0, '0, 2'd1);
    send_item(CMD_READ, 14'd1, '0, 2'd1);
    send_item(CMD_READ, 14'd63, '0, 2'd1);
    send_item(CMD_WRITE, 14'd63, 64'h0, 2'd3);
    send_item(CMD_READ, 14'd63, '0, 2'd3);
    send_item(CMD_DELETE, 14'd1, '0, 2'd0);
    send_item(CMD_READ, 14'd1, '0, 2'd0);
    send_item(CMD_DELETE, 14'd5, '0, 2'd0);             // never written
    send_item(CMD_WRITE, 14'd0, 64'h1234, 2'd0);        // size zero acts as delete
    send_item(CMD_READ, 14'd0, '0, 2'd0);
    send_item(CMD_READ, 14'd64, '0, 2'd1);
    send_item(CMD_WRITE, 14'd64, 64'h5555, 2'd1);
    send_item(CMD_DELETE, 14'd16383, '0, 2'd3);
    send_item(CMD_READ, 14'h2AAA, '0, 2'd2);
    send_item(2'd3, 14'd2, 64'hAAAA_5555_AAAA_5555, 2'd3);  // unused command
    send_item(CMD_READ, 14'd2, '0, 2'd1);
    idle_sender();
  endtask

  // mostly writes and reads over the valid names so the pages fill and swap
  task automatic test_random(input int n, input int s_pct, input int r_pct);
    logic [1:0]        cmd;
    logic [NAME_W-1:0] name;
    logic [1:0]        code;
    int                pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      cmd  = (pick < 40) ? CMD_READ : (pick < 88) ? CMD_WRITE : CMD_DELETE;
      pick = $urandom_range(99);
      if (pick < 5)       name = NAME_W'($urandom_range(16383, NUM_VARS));
      else if (pick < 50) name = NAME_W'($urandom_range(7));
      else                name = NAME_W'($urandom_range(NUM_VARS - 1));
      code = ($urandom_range(99) < 2) ? 2'd0 : 2'($urandom_range(3, 1));
      send_item(cmd, name, {$urandom, $urandom}, code);
    end
    idle_sender();
  endtask

  initial begin
    fail_count    = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_READ;
    in_if.var_name    = '0;
    in_if.write_value = '0;
    in_if.size_code   = 2'd1;

    // model reset state: page 0 valid, page 1 erased
    foreach (flash_mem[i]) flash_mem[i] = 16'hFFFF;
    foreach (offset_of[i]) begin
      offset_of[i] = 0;
      size_of[i]   = 0;
    end
    valid_pg  = 0;
    recv_pg   = NO_PAGE;
    erased_pg = 1;
    free_off  = 2;

    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(RAND_ITEMS, 0, 0);
    test_random(RAND_ITEMS, 45, 0);
    test_random(RAND_ITEMS, 0, 45);
    test_random(RAND_ITEMS, 37, 37);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/fees_pkg.sv
src/fees_if.sv
src/flash_eeprom_emulation_store.sv
tb/tb_flash_eeprom_emulation_store.sv
